>>> design/ccl_pkg.sv
// ----------------------------------------------------------------------------
// CRC framed command link package
// Shared widths, codes, CRC step function and controller/datapath bundles.
// ----------------------------------------------------------------------------
package ccl_pkg;

  localparam int KIND_W    = 2;
  localparam int CMD_W     = 8;
  localparam int LEN_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int VERDICT_W = 2;
  localparam int RETRY_W   = 4;
  localparam int POS_W     = 3;
  localparam int CRC_W     = 16;
  localparam int CRC_STEPS = 8;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_TX      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

  // Result kinds.
  localparam logic OUT_FRAME   = 1'b0;
  localparam logic OUT_VERDICT = 1'b1;

  localparam logic [CRC_W-1:0]   CRC_INIT      = 16'hFFFF;
  localparam logic [CRC_W-1:0]   CRC_POLY      = 16'hA001;
  localparam logic [BYTE_W-1:0]  SYNC_HI       = 8'hFF;
  localparam logic [BYTE_W-1:0]  SYNC_LO       = 8'hFE;
  localparam logic [BYTE_W-1:0]  STATUS_OK     = 8'h00;
  localparam logic [BYTE_W-1:0]  REPLY_MAX_LEN = 8'd3;
  localparam logic [RETRY_W-1:0] RETRY_RESET   = 4'd3;

  // Positions of the fields inside a seven byte reply.
  localparam logic [POS_W-1:0] RPOS_LEN    = 3'd2;
  localparam logic [POS_W-1:0] RPOS_STATUS = 3'd3;
  localparam logic [POS_W-1:0] RPOS_ECHO   = 3'd4;
  localparam logic [POS_W-1:0] RPOS_CRC_HI = 3'd5;
  localparam logic [POS_W-1:0] RPOS_CRC_LO = 3'd6;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ACK         = 2'd0,
    VERDICT_RESEND      = 2'd1,
    VERDICT_GIVE_UP     = 2'd2,
    VERDICT_NO_RESPONSE = 2'd3
  } ccl_verdict_t;

  typedef enum logic [1:0] {
    CRC_TX,
    CRC_RX,
    CRC_RS
  } ccl_crc_sel_t;

  typedef enum logic [3:0] {
    EM_SYNC_HI,
    EM_SYNC_LO,
    EM_LEN,
    EM_CMD,
    EM_DATA,
    EM_MEM,
    EM_TX_HI,
    EM_TX_LO,
    EM_RS_HI,
    EM_RS_LO,
    EM_VERDICT
  } ccl_emit_sel_t;

  typedef struct packed {
    logic          item_latch;
    logic          msg_start;
    logic          mem_wr;
    logic          tx_pc_clear;
    logic          crc_start;
    ccl_crc_sel_t  crc_sel;
    logic          reply_capture;
    logic          reply_advance;
    logic          reply_clear;
    logic          retries_inc;
    logic          retries_clr;
    logic          rs_init;
    logic          rs_read;
    logic          rs_idx_inc;
    logic          emit;
    ccl_emit_sel_t emit_sel;
    ccl_verdict_t  emit_verdict;
    logic          emit_last;
  } ccl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              first;
    logic              len_zero;
    logic              tx_last_byte;
    logic              tx_done;
    logic              rx_hit;
    logic              pos_zero;
    logic              pos_last;
    logic              reply_ok;
    logic              retry_avail;
    logic              rs_more;
    logic              crc_busy;
    logic              out_free;
  } ccl_status_t;

  // One bit of the reflected CRC-16/MODBUS shift.
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c);
    return c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

>>> design/ccl_if.sv
// ----------------------------------------------------------------------------
// CRC framed command link channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface ccl_item_if;
  import ccl_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CMD_W-1:0]  command;
  logic [LEN_W-1:0]  payload_length;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, kind, command, payload_length, data_byte, input ready);
  modport sink   (input valid, kind, command, payload_length, data_byte, output ready);
endinterface

interface ccl_result_if;
  import ccl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 out_kind;
  logic [BYTE_W-1:0]    frame_byte;
  logic [VERDICT_W-1:0] verdict;
  logic                 run_end;

  modport source (output valid, out_kind, frame_byte, verdict, run_end, input ready);
  modport sink   (input valid, out_kind, frame_byte, verdict, run_end, output ready);
endinterface

>>> design/ccl_datapath.sv
// ----------------------------------------------------------------------------
// CRC framed command link datapath
// Payload memory, CRC engine, reply collector, retry count and result register.
// ----------------------------------------------------------------------------
module ccl_datapath #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [ccl_pkg::RETRY_W-1:0]    cfg_wr_data,
  input  logic [ccl_pkg::KIND_W-1:0]     kind,
  input  logic [ccl_pkg::CMD_W-1:0]      command,
  input  logic [ccl_pkg::LEN_W-1:0]      payload_length,
  input  logic [ccl_pkg::BYTE_W-1:0]     data_byte,
  input  ccl_pkg::ccl_cmd_t              cmd,
  output ccl_pkg::ccl_status_t           status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic [ccl_pkg::BYTE_W-1:0]     frame_byte,
  output logic [ccl_pkg::VERDICT_W-1:0]  verdict,
  output logic                           run_end
);
  import ccl_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  // Latched input item.
  logic [KIND_W-1:0] item_kind;
  logic [CMD_W-1:0]  item_cmd;
  logic [LEN_W-1:0]  item_plen;
  logic [BYTE_W-1:0] item_db;

  // Message state.
  logic [CMD_W-1:0]  sent_command;
  logic [LEN_W-1:0]  sent_length;
  logic [LEN_W-1:0]  payload_count;
  logic [CRC_W-1:0]  tx_crc;

  // Reply collector.
  logic [POS_W-1:0]  reply_position;
  logic [CRC_W-1:0]  rx_crc;
  logic [BYTE_W-1:0] reply_length;
  logic [BYTE_W-1:0] reply_status_byte;
  logic [BYTE_W-1:0] reply_echo;
  logic [BYTE_W-1:0] reply_crc_high;

  logic [RETRY_W-1:0] retries_used;
  logic [RETRY_W-1:0] retry_limit;

  // Resend walker.
  logic [CRC_W-1:0]  rs_crc;
  logic [LEN_W-1:0]  rs_idx;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];

  // CRC engine.
  ccl_crc_sel_t      crc_sel_q;
  ccl_crc_sel_t      crc_target;
  logic [POS_W-1:0]  crc_cnt;
  logic              crc_busy;
  logic              crc_we;
  logic [CRC_W-1:0]  crc_cur;
  logic [BYTE_W-1:0] crc_byte;
  logic [CRC_W-1:0]  crc_new;

  logic [LEN_W-1:0]  plen_sat;
  logic [BYTE_W-1:0] pos_off;
  logic              out_free;

  logic              em_kind;
  logic [BYTE_W-1:0] em_byte;
  ccl_verdict_t      em_verdict;

  assign plen_sat = (item_plen > MAX_LEN) ? MAX_LEN : item_plen;
  assign pos_off  = {{(BYTE_W-POS_W){1'b0}}, reply_position}
                  - {{(BYTE_W-POS_W){1'b0}}, RPOS_ECHO};
  assign out_free = !out_valid || out_ready;

  always_comb begin
    status              = '0;
    status.kind         = item_kind;
    status.first        = (payload_count == '0);
    status.len_zero     = (sent_length == '0);
    status.tx_last_byte = ({1'b0, payload_count} + {{LEN_W{1'b0}}, 1'b1})
                          >= {1'b0, sent_length};
    status.tx_done      = (payload_count >= sent_length);
    status.rx_hit       = (reply_position >= RPOS_ECHO) && (pos_off < reply_length);
    status.pos_zero     = (reply_position == '0);
    status.pos_last     = (reply_position == RPOS_CRC_LO);
    status.reply_ok     = (reply_status_byte == STATUS_OK) &&
                          (reply_length <= REPLY_MAX_LEN) &&
                          (reply_crc_high == rx_crc[CRC_W-1:BYTE_W]) &&
                          (item_db == rx_crc[BYTE_W-1:0]) &&
                          (reply_echo == sent_command);
    status.retry_avail  = (retries_used < retry_limit);
    status.rs_more      = (rs_idx < sent_length);
    status.crc_busy     = crc_busy;
    status.out_free     = out_free;
  end

  // The engine works on one of three CRC registers, one bit per cycle.
  always_comb begin
    crc_target = cmd.crc_start ? cmd.crc_sel : crc_sel_q;
    crc_we     = cmd.crc_start || crc_busy;
    case (crc_target)
      CRC_TX:  crc_cur = tx_crc;
      CRC_RX:  crc_cur = rx_crc;
      CRC_RS:  crc_cur = rs_crc;
      default: crc_cur = tx_crc;
    endcase
    crc_byte = (crc_target == CRC_RS) ? rd_data : item_db;
    crc_new  = crc_step(cmd.crc_start ? (crc_cur ^ {{(CRC_W-BYTE_W){1'b0}}, crc_byte})
                                      : crc_cur);
  end

  always_comb begin
    em_kind    = OUT_FRAME;
    em_verdict = VERDICT_ACK;
    case (cmd.emit_sel)
      EM_SYNC_HI: em_byte = SYNC_HI;
      EM_SYNC_LO: em_byte = SYNC_LO;
      EM_LEN:     em_byte = {{(BYTE_W-LEN_W){1'b0}}, sent_length};
      EM_CMD:     em_byte = sent_command;
      EM_DATA:    em_byte = item_db;
      EM_MEM:     em_byte = rd_data;
      EM_TX_HI:   em_byte = tx_crc[CRC_W-1:BYTE_W];
      EM_TX_LO:   em_byte = tx_crc[BYTE_W-1:0];
      EM_RS_HI:   em_byte = rs_crc[CRC_W-1:BYTE_W];
      EM_RS_LO:   em_byte = rs_crc[BYTE_W-1:0];
      EM_VERDICT: begin
        em_kind    = OUT_VERDICT;
        em_byte    = '0;
        em_verdict = cmd.emit_verdict;
      end
      default:    em_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.item_latch) begin
      item_kind <= kind;
      item_cmd  <= command;
      item_plen <= payload_length;
      item_db   <= data_byte;
    end
    if (cmd.emit) begin
      out_kind   <= em_kind;
      frame_byte <= em_byte;
      verdict    <= em_verdict;
      run_end    <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      payload_mem[payload_count[AW-1:0]] <= item_db;
    end
    if (cmd.rs_read) begin
      rd_data <= payload_mem[rs_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_command      <= '0;
      sent_length       <= '0;
      payload_count     <= '0;
      tx_crc            <= CRC_INIT;
      reply_position    <= '0;
      rx_crc            <= CRC_INIT;
      reply_length      <= '0;
      reply_status_byte <= '0;
      reply_echo        <= '0;
      reply_crc_high    <= '0;
      retries_used      <= '0;
      retry_limit       <= RETRY_RESET;
      rs_crc            <= CRC_INIT;
      rs_idx            <= '0;
      crc_sel_q         <= CRC_TX;
      crc_cnt           <= '0;
      crc_busy          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        retry_limit <= cfg_wr_data;
      end

      if (cmd.msg_start) begin
        sent_command <= item_cmd;
        sent_length  <= plen_sat;
      end

      if (cmd.mem_wr) begin
        payload_count <= payload_count + 1'b1;
      end else if (cmd.tx_pc_clear) begin
        payload_count <= '0;
      end

      if (cmd.msg_start) begin
        tx_crc <= CRC_INIT;
      end else if (crc_we && crc_target == CRC_TX) begin
        tx_crc <= crc_new;
      end

      if (cmd.reply_clear) begin
        rx_crc <= CRC_INIT;
      end else if (crc_we && crc_target == CRC_RX) begin
        rx_crc <= crc_new;
      end

      if (cmd.rs_init) begin
        rs_crc <= CRC_INIT;
      end else if (crc_we && crc_target == CRC_RS) begin
        rs_crc <= crc_new;
      end

      if (cmd.crc_start) begin
        crc_sel_q <= cmd.crc_sel;
        crc_cnt   <= POS_W'(CRC_STEPS - 1);
        crc_busy  <= 1'b1;
      end else if (crc_busy) begin
        crc_cnt <= crc_cnt - 1'b1;
        if (crc_cnt == POS_W'(1)) begin
          crc_busy <= 1'b0;
        end
      end

      if (cmd.reply_capture) begin
        case (reply_position)
          RPOS_LEN:    reply_length      <= item_db;
          RPOS_STATUS: reply_status_byte <= item_db;
          RPOS_ECHO:   reply_echo        <= item_db;
          RPOS_CRC_HI: reply_crc_high    <= item_db;
          default: begin
          end
        endcase
      end

      if (cmd.reply_clear) begin
        reply_position    <= '0;
        reply_length      <= '0;
        reply_status_byte <= '0;
        reply_echo        <= '0;
        reply_crc_high    <= '0;
      end else if (cmd.reply_advance) begin
        reply_position <= reply_position + 1'b1;
      end

      if (cmd.msg_start || cmd.retries_clr) begin
        retries_used <= '0;
      end else if (cmd.retries_inc) begin
        retries_used <= retries_used + 1'b1;
      end

      if (cmd.rs_init) begin
        rs_idx <= '0;
      end else if (cmd.rs_idx_inc) begin
        rs_idx <= rs_idx + 1'b1;
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/ccl_controller.sv
// ----------------------------------------------------------------------------
// CRC framed command link controller
// Sequences frame output, reply collection, verdicts and resends.
// ----------------------------------------------------------------------------
module ccl_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  output ccl_pkg::ccl_cmd_t     cmd,
  input  ccl_pkg::ccl_status_t  status
);
  import ccl_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_H_SYNC_HI,
    ST_H_SYNC_LO,
    ST_H_LEN,
    ST_H_CMD,
    ST_T_DATA,
    ST_T_WAIT,
    ST_T_HI,
    ST_T_LO,
    ST_R_WAIT,
    ST_R_NEXT,
    ST_J_VERDICT,
    ST_NO_RESP,
    ST_S_READ,
    ST_S_BYTE,
    ST_S_WAIT,
    ST_S_HI,
    ST_S_LO
  } state_t;

  state_t       state;
  state_t       state_next;
  logic         resend_mode;
  logic         resend_mode_next;
  logic         judge_ok;
  logic         judge_ok_next;
  ccl_verdict_t verdict_code;

  assign item_ready = (state == ST_IDLE);

  always_comb begin
    if (judge_ok) begin
      verdict_code = VERDICT_ACK;
    end else if (status.retry_avail) begin
      verdict_code = VERDICT_RESEND;
    end else begin
      verdict_code = VERDICT_GIVE_UP;
    end
  end

  always_comb begin
    cmd              = '0;
    state_next       = state;
    resend_mode_next = resend_mode;
    judge_ok_next    = judge_ok;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.item_latch = 1'b1;
          state_next     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.kind)
          KIND_TX: begin
            if (status.first) begin
              cmd.msg_start    = 1'b1;
              resend_mode_next = 1'b0;
              state_next       = ST_H_SYNC_HI;
            end else begin
              state_next = ST_T_DATA;
            end
          end
          KIND_REPLY: begin
            cmd.reply_capture = 1'b1;
            cmd.crc_start     = status.rx_hit;
            cmd.crc_sel       = CRC_RX;
            state_next        = ST_R_WAIT;
          end
          KIND_TIMEOUT: begin
            if (status.pos_zero) begin
              state_next = ST_NO_RESP;
            end else begin
              judge_ok_next = 1'b0;
              state_next    = ST_J_VERDICT;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_H_SYNC_HI: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_SYNC_HI;
          state_next   = ST_H_SYNC_LO;
        end
      end
      ST_H_SYNC_LO: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_SYNC_LO;
          state_next   = ST_H_LEN;
        end
      end
      ST_H_LEN: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_LEN;
          state_next   = ST_H_CMD;
        end
      end
      ST_H_CMD: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_CMD;
          state_next   = resend_mode ? ST_S_READ : ST_T_DATA;
        end
      end
      ST_T_DATA: begin
        if (status.len_zero) begin
          state_next = ST_T_HI;
        end else if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_DATA;
          cmd.emit_last = !status.tx_last_byte;
          cmd.mem_wr    = 1'b1;
          cmd.crc_start = 1'b1;
          cmd.crc_sel   = CRC_TX;
          state_next    = ST_T_WAIT;
        end
      end
      ST_T_WAIT: begin
        if (!status.crc_busy) begin
          state_next = status.tx_done ? ST_T_HI : ST_IDLE;
        end
      end
      ST_T_HI: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_TX_HI;
          state_next   = ST_T_LO;
        end
      end
      ST_T_LO: begin
        if (status.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = EM_TX_LO;
          cmd.emit_last   = 1'b1;
          cmd.tx_pc_clear = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_R_WAIT: begin
        if (!status.crc_busy) begin
          state_next = ST_R_NEXT;
        end
      end
      ST_R_NEXT: begin
        if (status.pos_last) begin
          judge_ok_next = status.reply_ok;
          state_next    = ST_J_VERDICT;
        end else begin
          cmd.reply_advance = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      ST_J_VERDICT: begin
        if (status.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_sel     = EM_VERDICT;
          cmd.emit_verdict = verdict_code;
          cmd.reply_clear  = 1'b1;
          if (verdict_code == VERDICT_RESEND) begin
            cmd.retries_inc  = 1'b1;
            cmd.rs_init      = 1'b1;
            resend_mode_next = 1'b1;
            state_next       = ST_H_SYNC_HI;
          end else begin
            cmd.emit_last   = 1'b1;
            cmd.retries_clr = 1'b1;
            state_next      = ST_IDLE;
          end
        end
      end
      ST_NO_RESP: begin
        if (status.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_sel     = EM_VERDICT;
          cmd.emit_verdict = VERDICT_NO_RESPONSE;
          cmd.emit_last    = 1'b1;
          cmd.retries_clr  = 1'b1;
          cmd.reply_clear  = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_S_READ: begin
        if (status.rs_more) begin
          cmd.rs_read = 1'b1;
          state_next  = ST_S_BYTE;
        end else begin
          state_next = ST_S_HI;
        end
      end
      ST_S_BYTE: begin
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_sel   = EM_MEM;
          cmd.crc_start  = 1'b1;
          cmd.crc_sel    = CRC_RS;
          cmd.rs_idx_inc = 1'b1;
          state_next     = ST_S_WAIT;
        end
      end
      ST_S_WAIT: begin
        if (!status.crc_busy) begin
          state_next = ST_S_READ;
        end
      end
      ST_S_HI: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_RS_HI;
          state_next   = ST_S_LO;
        end
      end
      ST_S_LO: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_RS_LO;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      resend_mode <= 1'b0;
      judge_ok    <= 1'b0;
    end else begin
      state       <= state_next;
      resend_mode <= resend_mode_next;
      judge_ok    <= judge_ok_next;
    end
  end

  a_emit_has_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result emitted while the output register is still full");

  a_crc_not_restarted: assert property (@(posedge clk) disable iff (rst)
    cmd.crc_start |-> !status.crc_busy)
    else $error("CRC engine started while a byte update is in progress");

  a_idle_crc_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !status.crc_busy)
    else $error("controller idle while the CRC engine is still busy");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (status.crc_busy && !$past(status.crc_busy)) |-> $past(cmd.crc_start))
    else $error("CRC engine became busy without a start command");

  a_mem_single_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_wr && cmd.rs_read))
    else $error("payload memory written and read in the same cycle");

endmodule

>>> design/crc_framed_command_link.sv
// ----------------------------------------------------------------------------
// CRC framed command link
// Builds CRC-16/MODBUS command frames, checks replies and resends on failure.
// ----------------------------------------------------------------------------
// A middle payload byte is emitted after its transaction is latched, and the
// block takes no new item until the bit serial CRC engine has finished that
// byte. A first item also emits the four header bytes, a last item the two CRC
// bytes. A reply byte is captured and may also enter the reply CRC first.
// A resend reads each stored payload byte from memory and runs it through the CRC.
// Reset is synchronous; the payload memory is never cleared.
// ----------------------------------------------------------------------------
module crc_framed_command_link #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [ccl_pkg::RETRY_W-1:0] cfg_wr_data,
  ccl_item_if.sink                    items,
  ccl_result_if.source                results
);
  import ccl_pkg::*;

  // The controller and the datapath talk only through these two bundles.
  ccl_cmd_t    cmd;
  ccl_status_t status;

  // The controller takes one item at a time. It returns to idle as soon as
  // the last result of an item sits in the output register, so the next
  // transaction can be accepted while that result still waits downstream.
  ccl_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (items.ready),
    .cmd        (cmd),
    .status     (status)
  );

  // The datapath holds the payload memory used for resends, the shared CRC
  // engine that serves the transmit, reply and resend checksums, the reply
  // collector, the retry count and the result register.
  ccl_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .kind           (items.kind),
    .command        (items.command),
    .payload_length (items.payload_length),
    .data_byte      (items.data_byte),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .out_kind       (results.out_kind),
    .frame_byte     (results.frame_byte),
    .verdict        (results.verdict),
    .run_end        (results.run_end)
  );

endmodule
